>>> rtl/core/rv32im_instruction_execute_top_assert.svh
// Assertion macros for the execute core.
`ifndef RV32IM_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH
`define RV32IM_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RVX_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RVX_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RVX_ASSERT(label, clk, rst, prop, msg)
`define RVX_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/rvx_pkg.sv
// ----------------------------------------------------------------------------
// rvx_pkg
// Opcodes, state encoding and shared types of the RV32IM execute core.
// ----------------------------------------------------------------------------
package rvx_pkg;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [31:0] INSTR_ECALL  = 32'h00000073;
  localparam logic [31:0] INSTR_EBREAK = 32'h00100073;
  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT = 7'h20;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_MULH, ST_OUT
  } state_t;

  // divider request and answer
  typedef struct packed {
    logic        start;
    logic        sgn;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;
endpackage

>>> rtl/core/rvx_regfile.sv
// ----------------------------------------------------------------------------
// rvx_regfile
// 32 x 32 register file, one write port, two registered read ports.
// Entries carry valid bits so that a never-written register reads as zero.
// ----------------------------------------------------------------------------
module rvx_regfile import rvx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  ra,
  input  logic [4:0]  rb,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [31:0] wd,
  output logic [31:0] qa,
  output logic [31:0] qb
);
  logic [31:0] mem [32];
  logic [31:0] vld;
  logic [31:0] da, db;
  logic        va, vb;

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (we) vld[wa] <= (wa != 5'd0);
  end

  // registered reads
  always_ff @(posedge clk) begin
    da <= mem[ra];
    db <= mem[rb];
    va <= vld[ra];
    vb <= vld[rb];
  end

  assign qa = va ? da : 32'd0;
  assign qb = vb ? db : 32'd0;
endmodule

>>> rtl/core/rvx_div.sv
// ----------------------------------------------------------------------------
// rvx_div
// Radix-2 restoring divider, one quotient bit per cycle.
// Handles divide by zero and signed overflow per the ISA.
// ----------------------------------------------------------------------------
module rvx_div import rvx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [31:0] q, r, d, ain;
  logic [5:0]  cnt;
  logic        busy, nq, nr, zero, ovf;
  logic [31:0] ma, mb;
  logic [33:0] trial;
  logic [32:0] rsh;
  logic        done;
  logic [31:0] quo_v, rem_v;

  assign ma = (req.sgn && req.a[31]) ? 32'd0 - req.a : req.a;
  assign mb = (req.sgn && req.b[31]) ? 32'd0 - req.b : req.b;
  assign rsh = {r, q[31]};
  assign trial = {1'b0, rsh} - {2'b00, d};

  // iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else cnt <= cnt - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q <= ma;
      r <= '0;
      d <= mb;
      ain <= req.a;
      nq <= req.sgn && (req.a[31] ^ req.b[31]);
      nr <= req.sgn && req.a[31];
      zero <= (req.b == 32'd0);
      ovf <= req.sgn && (req.a == 32'h80000000) && (req.b == 32'hFFFFFFFF);
    end else if (busy && cnt != 6'd0) begin
      if (!trial[33]) begin
        r <= trial[31:0];
        q <= {q[30:0], 1'b1};
      end else begin
        r <= rsh[31:0];
        q <= {q[30:0], 1'b0};
      end
    end
  end

  // fix up signs and special cases
  always_comb begin
    if (zero) begin
      quo_v = 32'hFFFFFFFF;
      rem_v = ain;
    end else if (ovf) begin
      quo_v = 32'h80000000;
      rem_v = 32'd0;
    end else begin
      quo_v = nq ? 32'd0 - q : q;
      rem_v = nr ? 32'd0 - r : r;
    end
  end

  assign rsp = {done, quo_v, rem_v};

  `include "rv32im_instruction_execute_top_assert.svh"
  `RVX_ASSERT(a_no_restart, clk, rst, busy |-> !req.start, "divider restarted while busy")
  `RVX_ASSERT(a_done_idle, clk, rst, done |-> !busy, "done while busy")
  `RVX_ASSERT(a_done_end, clk, rst, done |-> $past(busy && cnt == 6'd0), "early done")
endmodule

>>> rtl/core/rv32im_instruction_execute_top.sv
// ----------------------------------------------------------------------------
// rv32im_instruction_execute_top
// RV32IM execute core with memory-held register file.
// ----------------------------------------------------------------------------
// Usage: an input beat (valid/stall) carries mode 0 with an instruction
// word fetched at next_pc, or mode 1 with load data for a pending load.
// Each input beat yields exactly one output beat holding next_pc, halt
// status, any data memory request, any writeback and the retired count.
// Most instructions pass accept, register file read, execute and output;
// MULH variants add a second stage for the high product, and DIV/REM wait
// on the one-bit-per-cycle divider. One item is in flight at a time;
// in_stall is high from acceptance until the output beat is taken.
// start_pc is written through cfg_we/cfg_wdata into the PC; the user must
// write it only while idle, as the block does not enforce this.
// Synchronous reset clears the PC to zero (start_pc reset), the halt and
// load state, the counter and the register file valid bits. While the
// receiver stalls, the output beat holds and no new item is taken.
// ----------------------------------------------------------------------------
module rv32im_instruction_execute_top import rvx_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [31:0] instr,
  input  logic [31:0] load_data,
  input  logic        access_error,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_pc,
  output logic        halted,
  output logic        mem_valid,
  output logic        mem_write,
  output logic [1:0]  mem_size,
  output logic [31:0] mem_addr,
  output logic [31:0] mem_wdata,
  output logic        wb_valid,
  output logic [4:0]  wb_reg,
  output logic [31:0] wb_value,
  output logic [63:0] retired
);
  state_t state, state_next;
  logic [31:0] pc, ir, ld;
  logic        md, err, hlt, lp;
  logic [4:0]  ldst;
  logic [2:0]  lkind;
  logic [63:0] cnt;
  logic [31:0] a, b;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [63:0] prod;
  logic [31:0] mh_fix;

  wire in_acc = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  rvx_regfile u_rf (
    .clk(clk), .rst(rst), .ra(ir[19:15]), .rb(ir[24:20]),
    .we(rf_we), .wa(rf_wa), .wd(rf_wd), .qa(a), .qb(b)
  );

  rvx_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // decode fields
  wire [6:0]  opc = ir[6:0];
  wire [4:0]  rd = ir[11:7];
  wire [2:0]  f3 = ir[14:12];
  wire [6:0]  f7 = ir[31:25];
  wire [31:0] imm_i = {{20{ir[31]}}, ir[31:20]};
  wire [31:0] imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
  wire [31:0] imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
  wire [31:0] imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
  wire [31:0] imm_u = {ir[31:12], 12'd0};
  wire        op_md = (opc == OPC_OP) && (f7 == F7_MULDIV);
  wire        is_div = op_md && f3[2];
  wire        is_mulh = op_md && !f3[2] && (f3 != 3'd0);
  wire        exec_i = !hlt && md == 1'b0 && !lp && !err;

  // start divider on entry to divide wait
  always_comb begin
    dreq.start = (state == ST_EXEC) && exec_i && is_div;
    dreq.sgn = !f3[0];
    dreq.a = a;
    dreq.b = b;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc) state_next = ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: begin
        if (exec_i && is_div) state_next = ST_DIV;
        else if (exec_i && is_mulh) state_next = ST_MULH;
        else state_next = ST_OUT;
      end
      ST_DIV: if (drsp.done) state_next = ST_OUT;
      ST_MULH: state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // capture input beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      md <= mode;
      ir <= instr;
      ld <= load_data;
      err <= access_error;
    end
  end

  // ALU
  logic [31:0] res, npc;
  logic        wr, hnew, take;
  logic [4:0]  sh;
  always_comb begin
    res = 32'd0;
    wr = 1'b0;
    hnew = 1'b0;
    take = 1'b0;
    npc = pc + 32'd4;
    sh = ir[24:20];
    case (opc)
      OPC_LUI: begin res = imm_u; wr = 1'b1; end
      OPC_AUIPC: begin res = pc + imm_u; wr = 1'b1; end
      OPC_JAL: begin res = pc + 32'd4; wr = 1'b1; npc = pc + imm_j; end
      OPC_JALR: begin res = pc + 32'd4; wr = 1'b1; npc = (a + imm_i) & ~32'd1; end
      OPC_BRANCH: begin
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = $signed(a) < $signed(b);
          3'd5: take = !($signed(a) < $signed(b));
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: take = 1'b0;
        endcase
        if (take) npc = pc + imm_b;
      end
      OPC_LOAD, OPC_STORE, OPC_FENCE: ;
      OPC_OPIMM: begin
        wr = 1'b1;
        case (f3)
          3'd0: res = a + imm_i;
          3'd1: res = a << sh;
          3'd2: res = {31'd0, $signed(a) < $signed(imm_i)};
          3'd3: res = {31'd0, a < imm_i};
          3'd4: res = a ^ imm_i;
          3'd5: res = (f7 == F7_ZERO) ? a >> sh : 32'($signed(a) >>> sh);
          3'd6: res = a | imm_i;
          default: res = a & imm_i;
        endcase
      end
      OPC_OP: begin
        wr = 1'b1;
        if (f7 == F7_MULDIV) res = a * b;
        else if (f7 == F7_ALT) begin
          if (f3 == 3'd0) res = a - b;
          else if (f3 == 3'd5) res = 32'($signed(a) >>> b[4:0]);
          else wr = 1'b0;
        end else if (f7 == F7_ZERO) begin
          case (f3)
            3'd0: res = a + b;
            3'd1: res = a << b[4:0];
            3'd2: res = {31'd0, $signed(a) < $signed(b)};
            3'd3: res = {31'd0, a < b};
            3'd4: res = a ^ b;
            3'd5: res = a >> b[4:0];
            3'd6: res = a | b;
            default: res = a & b;
          endcase
        end else wr = 1'b0;
      end
      OPC_SYSTEM: hnew = (ir == INSTR_ECALL) || (ir == INSTR_EBREAK);
      default: hnew = 1'b1;
    endcase
  end

  // unsigned high product, then sign correction in the next stage
  always_ff @(posedge clk) begin
    prod <= {32'd0, a} * {32'd0, b};
    mh_fix <= ((f3 != 3'd3) && a[31] ? b : 32'd0) + ((f3 == 3'd1) && b[31] ? a : 32'd0);
  end

  // load extend
  logic [31:0] lv;
  always_comb begin
    case (lkind)
      3'd0: lv = {{24{ld[7]}}, ld[7:0]};
      3'd1: lv = {{16{ld[15]}}, ld[15:0]};
      3'd4: lv = {24'd0, ld[7:0]};
      3'd5: lv = {16'd0, ld[15:0]};
      default: lv = ld;
    endcase
  end

  wire ld_ok = (f3 == 3'd0) || (f3 == 3'd1) || (f3 == 3'd2) || (f3 == 3'd4) || (f3 == 3'd5);
  wire st_ok = (f3 <= 3'd2);

  // writeback to register file
  always_comb begin
    rf_we = 1'b0;
    rf_wa = rd;
    rf_wd = 32'd0;
    if (state == ST_EXEC && exec_i && wr && !is_div && !is_mulh) begin
      rf_we = 1'b1;
      rf_wd = (rd == 5'd0) ? 32'd0 : res;
    end else if (state == ST_DIV && drsp.done) begin
      rf_we = 1'b1;
      rf_wd = (rd == 5'd0) ? 32'd0 : (f3[1] ? drsp.rem : drsp.quo);
    end else if (state == ST_MULH) begin
      rf_we = 1'b1;
      rf_wd = (rd == 5'd0) ? 32'd0 : prod[63:32] - mh_fix;
    end else if (state == ST_EXEC && !hlt && md && lp && !err) begin
      rf_we = 1'b1;
      rf_wa = ldst;
      rf_wd = (ldst == 5'd0) ? 32'd0 : lv;
    end
  end

  // architectural state and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 32'd0;
      hlt <= 1'b0;
      lp <= 1'b0;
      ldst <= 5'd0;
      lkind <= 3'd0;
      cnt <= 64'd0;
    end else begin
      if (cfg_we) pc <= cfg_wdata;
      if (state == ST_EXEC) begin
        if (!hlt && md == 1'b0 && !lp && err) hlt <= 1'b1;
        if (exec_i) begin
          pc <= npc;
          cnt <= cnt + 64'd1;
          if (hnew) hlt <= 1'b1;
          if (opc == OPC_LOAD && ld_ok) begin
            lp <= 1'b1;
            ldst <= rd;
            lkind <= f3;
          end
        end
        if (!hlt && md && lp) lp <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      mem_valid <= 1'b0;
      mem_write <= 1'b0;
      mem_size <= 2'd0;
      mem_addr <= 32'd0;
      mem_wdata <= 32'd0;
      wb_valid <= rf_we;
      wb_reg <= rf_we ? rf_wa : 5'd0;
      wb_value <= rf_we ? rf_wd : 32'd0;
      if (exec_i && opc == OPC_LOAD && ld_ok) begin
        mem_valid <= 1'b1;
        mem_size <= f3[1:0];
        mem_addr <= a + imm_i;
      end
      if (exec_i && opc == OPC_STORE && st_ok) begin
        mem_valid <= 1'b1;
        mem_write <= 1'b1;
        mem_size <= f3[1:0];
        mem_addr <= a + imm_s;
        mem_wdata <= b;
      end
    end else if (rf_we) begin
      wb_valid <= 1'b1;
      wb_reg <= rf_wa;
      wb_value <= rf_wd;
    end
  end

  assign next_pc = pc;
  assign halted = hlt;
  assign retired = cnt;

  `include "rv32im_instruction_execute_top_assert.svh"
  `RVX_ASSERT(a_one_beat, clk, rst, (out_valid && !out_stall) |=> !out_valid, "output beat repeated")
  `RVX_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> out_valid && $stable(next_pc), "stalled beat changed")
  `RVX_ASSERT(a_cnt_step, clk, rst, (state != ST_EXEC) |=> $stable(cnt), "counter moved outside execute")
  `RVX_ASSERT(a_halt_sticky, clk, rst, hlt |=> hlt, "halt cleared")
  `RVX_ASSERT_NR(a_reset_idle, clk, rst |=> state == ST_IDLE, "not idle after reset")
endmodule
